// ===== hdl/rgb_hsv_convert_and_saturate_assert.svh =====
// Assertion macros for the RGB/HSV converter.
// Depends on nothing; included by the top level.
`ifndef RGB_HSV_CONVERT_AND_SATURATE_ASSERT_SVH
`define RGB_HSV_CONVERT_AND_SATURATE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define RHS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RHS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ===== hdl/rhs_pkg.sv =====
// Package for the RGB/HSV converter: command codes and constants.
// Depends on nothing.
package rhs_pkg;
	typedef enum logic [1:0] {
		CMD_RGB2HSV = 2'd0,
		CMD_HSV2RGB = 2'd1,
		CMD_SETSAT  = 2'd2,
		CMD_CAPSAT  = 2'd3
	} cmd_t;
	localparam logic [7:0] HUE_G = 8'd85;
	localparam logic [7:0] HUE_B = 8'd171;
	localparam logic [7:0] SECT = 8'd43;
endpackage

// ===== hdl/rhs_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface rhs_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rgb_hsv_convert_and_saturate.sv =====
// Top level of the RGB/HSV converter and saturation adjuster.
// Depends on rhs_pkg, rhs_if and the assertion header.
//
// Usage: items enter on channel in (valid/ready, payload cmd, chan_a, chan_b,
// chan_c, sat_target) and results leave on channel out (out_a, out_b, out_c).
// Each transfer in yields exactly one transfer out, in order.
// Throughput is one item per cycle while out.ready holds, set by a fully
// pipelined datapath of two shared-free dividers (unrolled restoring
// stages, four quotient bits per stage) and the HSV to RGB multiplier stages.
// The pipeline advances only when its last stage is empty or being taken,
// so a receiver stall holds every stage in place and in.ready falls.
// Reset clears all valid bits; payload registers are not reset.
// There is no configuration port.
`include "rgb_hsv_convert_and_saturate_assert.svh"
module rgb_hsv_convert_and_saturate
	import rhs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	rhs_if.sink in,
	rhs_if.source out
);
	localparam int NS = 9;
	logic adv;
	logic [NS-1:0] vld_q;

	assign adv = !vld_q[NS-1] || out.ready;
	assign in.ready = adv;
	assign out.valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NS-2:0], in.valid};
		end
	end

	// Stage 1: max, min, sector, signed difference.
	logic [1:0] cmd_s1;
	logic [7:0] a_s1, b_s1, c_s1, t_s1, mx_s1, d_s1, base_s1;
	logic neg_s1;
	logic [7:0] ad_s1;
	logic [7:0] ia, ib, ic, mx, mn;
	logic [8:0] df;
	logic [7:0] bs;
	always_comb begin
		ia = in.data.chan_a; ib = in.data.chan_b; ic = in.data.chan_c;
		mx = (ia > ib) ? ((ia > ic) ? ia : ic) : ((ib > ic) ? ib : ic);
		mn = (ia < ib) ? ((ia < ic) ? ia : ic) : ((ib < ic) ? ib : ic);
		if (mx == ia) begin
			bs = 8'd0; df = {1'b0, ib} - {1'b0, ic};
		end else if (mx == ib) begin
			bs = HUE_G; df = {1'b0, ic} - {1'b0, ia};
		end else begin
			bs = HUE_B; df = {1'b0, ia} - {1'b0, ib};
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= in.data.cmd; a_s1 <= ia; b_s1 <= ib; c_s1 <= ic;
			t_s1 <= in.data.sat_target; mx_s1 <= mx; d_s1 <= mx - mn;
			base_s1 <= bs; neg_s1 <= df[8];
			ad_s1 <= df[8] ? 8'(-df) : df[7:0];
		end
	end

	// Stage 2: numerators for both divisions.
	logic [1:0] cmd_s2;
	logic [7:0] a_s2, b_s2, c_s2, t_s2, mx_s2, d_s2, base_s2;
	logic neg_s2;
	logic [15:0] ns_s2, nh_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2 <= cmd_s1; a_s2 <= a_s1; b_s2 <= b_s1; c_s2 <= c_s1;
			t_s2 <= t_s1; mx_s2 <= mx_s1; d_s2 <= d_s1; base_s2 <= base_s1;
			neg_s2 <= neg_s1;
			ns_s2 <= 16'(d_s1) * 16'd255;
			nh_s2 <= 16'(ad_s1) * 16'(SECT);
		end
	end

	// Stages 3 and 4: restoring division, four quotient bits per stage.
	// Both quotients are known to fit in eight bits.
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] a, b, c, t, mx, d, base;
		logic neg;
		logic [15:0] rs, rh;
		logic [7:0] qs, qh;
	} dv_t;
	dv_t dv_s3, dv_s4, dv4_n;

	function automatic void divstep4(input logic [15:0] rin, input logic [7:0] den,
			input logic [2:0] lsb, output logic [15:0] rout, output logic [3:0] q);
		logic [15:0] r;
		logic [16:0] tr;
		r = rin;
		q = '0;
		for (int i = 3; i >= 0; i--) begin
			tr = {1'b0, r} - ({9'd0, den} << (3'(i) + lsb));
			if (!tr[16]) begin
				r = tr[15:0];
				q[i] = 1'b1;
			end
		end
		rout = r;
	endfunction

	logic [15:0] r3s, r3h, r4s, r4h;
	logic [3:0] q3s, q3h, q4s, q4h;
	always_comb begin
		divstep4(ns_s2, mx_s2, 3'd4, r3s, q3s);
		divstep4(nh_s2, d_s2, 3'd4, r3h, q3h);
		divstep4(dv_s3.rs, dv_s3.mx, 3'd0, r4s, q4s);
		divstep4(dv_s3.rh, dv_s3.d, 3'd0, r4h, q4h);
		dv4_n = dv_s3;
		dv4_n.rs = r4s;
		dv4_n.rh = r4h;
		dv4_n.qs = {dv_s3.qs[7:4], q4s};
		dv4_n.qh = {dv_s3.qh[7:4], q4h};
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s3 <= '{cmd: cmd_s2, a: a_s2, b: b_s2, c: c_s2, t: t_s2, mx: mx_s2,
				d: d_s2, base: base_s2, neg: neg_s2, rs: r3s, rh: r3h,
				qs: {q3s, 4'd0}, qh: {q3h, 4'd0}};
			dv_s4 <= dv4_n;
		end
	end

	// Stage 5: HSV result and selection of the HSV to RGB operands.
	logic [1:0] cmd_s5;
	logic [7:0] a_s5, b_s5, c_s5, h_s5, s_s5, v_s5, hh_s5, hs_s5, hv_s5;
	logic pass_s5;
	logic [7:0] sv, hv, qh8;
	always_comb begin
		qh8 = dv_s4.qh[7:0];
		if (dv_s4.mx == 8'd0 || dv_s4.d == 8'd0) begin
			sv = 8'd0; hv = 8'd0;
		end else begin
			sv = dv_s4.qs[7:0];
			hv = dv_s4.neg ? 8'(dv_s4.base - qh8) : 8'(dv_s4.base + qh8);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s5 <= dv_s4.cmd; a_s5 <= dv_s4.a; b_s5 <= dv_s4.b; c_s5 <= dv_s4.c;
			h_s5 <= hv; s_s5 <= sv; v_s5 <= dv_s4.mx;
			pass_s5 <= (dv_s4.cmd == CMD_CAPSAT) && !(sv > dv_s4.t);
			if (dv_s4.cmd == CMD_HSV2RGB) begin
				hh_s5 <= dv_s4.a; hs_s5 <= dv_s4.b; hv_s5 <= dv_s4.c;
			end else begin
				hh_s5 <= hv; hs_s5 <= dv_s4.t; hv_s5 <= dv_s4.mx;
			end
		end
	end

	// Stage 6: region and remainder.
	typedef struct packed {
		logic [1:0] cmd;
		logic pass;
		logic [7:0] a, b, c, h, s, v, hs, hv;
		logic [2:0] reg3;
		logic [7:0] rem;
	} hr_t;
	hr_t hr_s6, hr_s7, hr_s8;
	logic [2:0] rg;
	logic [7:0] hm;
	always_comb begin
		rg = 3'd0; hm = hh_s5;
		for (int i = 0; i < 5; i++) begin
			if (hm >= SECT) begin
				hm = hm - SECT; rg = rg + 3'd1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			hr_s6 <= '{cmd: cmd_s5, pass: pass_s5, a: a_s5, b: b_s5, c: c_s5,
				h: h_s5, s: s_s5, v: v_s5, hs: hs_s5, hv: hv_s5, reg3: rg,
				rem: 8'(hm * 8'd6)};
		end
	end

	// Stage 7: inner products; stage 8: outer products.
	logic [7:0] ip_s7, iq_s7, it_s7, p_s8, q_s8, t_s8;
	logic [15:0] sq, st;
	always_comb begin
		sq = 16'(hr_s6.hs) * 16'(hr_s6.rem);
		st = 16'(hr_s6.hs) * 16'(8'd255 - hr_s6.rem);
	end
	logic [15:0] pp, pq, pt;
	always_comb begin
		pp = 16'(hr_s7.hv) * 16'(ip_s7);
		pq = 16'(hr_s7.hv) * 16'(iq_s7);
		pt = 16'(hr_s7.hv) * 16'(it_s7);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			hr_s7 <= hr_s6;
			ip_s7 <= 8'd255 - hr_s6.hs;
			iq_s7 <= 8'd255 - sq[15:8];
			it_s7 <= 8'd255 - st[15:8];
			hr_s8 <= hr_s7;
			p_s8 <= pp[15:8]; q_s8 <= pq[15:8]; t_s8 <= pt[15:8];
		end
	end

	// Stage 9: region mux and mode selection.
	logic [7:0] rr, gg, bb, ya, yb, yc;
	always_comb begin
		case (hr_s8.reg3)
			3'd0: begin rr = hr_s8.hv; gg = t_s8; bb = p_s8; end
			3'd1: begin rr = q_s8; gg = hr_s8.hv; bb = p_s8; end
			3'd2: begin rr = p_s8; gg = hr_s8.hv; bb = t_s8; end
			3'd3: begin rr = p_s8; gg = q_s8; bb = hr_s8.hv; end
			3'd4: begin rr = t_s8; gg = p_s8; bb = hr_s8.hv; end
			default: begin rr = hr_s8.hv; gg = p_s8; bb = q_s8; end
		endcase
		if (hr_s8.hs == 8'd0) begin
			rr = hr_s8.hv; gg = hr_s8.hv; bb = hr_s8.hv;
		end
		if (hr_s8.cmd == CMD_RGB2HSV) begin
			ya = hr_s8.h; yb = hr_s8.s; yc = hr_s8.v;
		end else if (hr_s8.pass) begin
			ya = hr_s8.a; yb = hr_s8.b; yc = hr_s8.c;
		end else begin
			ya = rr; yb = gg; yc = bb;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out.data.out_a <= ya; out.data.out_b <= yb; out.data.out_c <= yc;
		end
	end

	`RHS_ASSERT_NEXT(a_stall_hold, clk, arst_n, out.valid && !out.ready, out.valid)
	`RHS_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out.valid, in.ready)
	`RHS_ASSERT_NEXT(a_fill, clk, arst_n, in.valid && in.ready, vld_q[0])
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the RGB/HSV converter and saturation adjuster.
// Depends on rhs_pkg, rhs_if and rgb_hsv_convert_and_saturate; a scoreboard
// built from an in-bench color model checks each output transfer in order.
module tb_top;
	import rhs_pkg::*;

	typedef struct packed {
		cmd_t cmd;
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
		logic [7:0] sat_target;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] out_a;
		logic [7:0] out_b;
		logic [7:0] out_c;
	} pixel_out_t;

	typedef struct {
		pixel_in_t px;
		int gap;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n;
	rhs_if #(.payload_t(pixel_in_t)) in_if ();
	rhs_if #(.payload_t(pixel_out_t)) out_if ();

	rgb_hsv_convert_and_saturate dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_if.sink),
		.out(out_if.source)
	);

	stim_t pending_px[$];
	pixel_out_t expected_px[$];
	int errors = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	bit long_hold_done = 0;
	bit calm = 0;
	int in_wait = 0;
	int out_stall = 0;
	int hold_cnt = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void to_hsv(input int unsigned r, g, b,
			output int unsigned h, s, v);
		int unsigned mx, mn, d;
		int base, diff, q;
		mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
		mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
		d = mx - mn;
		v = mx;
		h = 0;
		s = 0;
		if (mx != 0) begin
			s = (255 * d) / mx;
			if (s != 0) begin
				if (mx == r) begin
					base = 0;
					diff = int'(g) - int'(b);
				end else if (mx == g) begin
					base = 85;
					diff = int'(b) - int'(r);
				end else begin
					base = 171;
					diff = int'(r) - int'(g);
				end
				q = (43 * diff) / int'(d);
				h = (base + q) & 255;
			end
		end
	endfunction

	function automatic void to_rgb(input int unsigned h, s, v,
			output int unsigned r, g, b);
		int unsigned region, rem, p, q, t;
		if (s == 0) begin
			r = v;
			g = v;
			b = v;
		end else begin
			region = h / 43;
			rem = (h - region * 43) * 6;
			p = (v * (255 - s)) >> 8;
			q = (v * (255 - ((s * rem) >> 8))) >> 8;
			t = (v * (255 - ((s * (255 - rem)) >> 8))) >> 8;
			case (region)
				0: begin r = v; g = t; b = p; end
				1: begin r = q; g = v; b = p; end
				2: begin r = p; g = v; b = t; end
				3: begin r = p; g = q; b = v; end
				4: begin r = t; g = p; b = v; end
				default: begin r = v; g = p; b = q; end
			endcase
		end
	endfunction

	function automatic pixel_out_t convert_pixel(input pixel_in_t px);
		int unsigned x, y, z, h, s, v;
		pixel_out_t res;
		case (px.cmd)
			CMD_RGB2HSV: to_hsv(px.chan_a, px.chan_b, px.chan_c, x, y, z);
			CMD_HSV2RGB: to_rgb(px.chan_a, px.chan_b, px.chan_c, x, y, z);
			default: begin
				to_hsv(px.chan_a, px.chan_b, px.chan_c, h, s, v);
				if (px.cmd == CMD_SETSAT || s > px.sat_target) begin
					to_rgb(h, px.sat_target, v, x, y, z);
				end else begin
					x = px.chan_a;
					y = px.chan_b;
					z = px.chan_c;
				end
			end
		endcase
		res.out_a = x[7:0];
		res.out_b = y[7:0];
		res.out_c = z[7:0];
		return res;
	endfunction

	task automatic add_pixel(input cmd_t c, input int a, b, d, t);
		stim_t st;
		st.px.cmd = c;
		st.px.chan_a = a[7:0];
		st.px.chan_b = b[7:0];
		st.px.chan_c = d[7:0];
		st.px.sat_target = t[7:0];
		st.gap = calm ? 0 : $urandom_range(0, 5);
		pending_px.push_back(st);
	endtask

	// Sender: one pixel per transfer, random gaps between pixels outside calm spells.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.data <= '0;
			in_wait <= 0;
		end else if (!in_if.valid || in_if.ready) begin
			if (in_if.valid) begin
				expected_px.push_back(convert_pixel(in_if.data));
			end
			if (in_wait > 0) begin
				in_if.valid <= 1'b0;
				in_wait <= in_wait - 1;
			end else if (pending_px.size() > 0) begin
				in_if.data <= pending_px[0].px;
				in_wait <= pending_px[0].gap;
				in_if.valid <= 1'b1;
				void'(pending_px.pop_front());
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// Long hold-off of the receiver, counted here so the pipeline backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			long_hold_done <= 1'b0;
		end else if (!long_hold_done && results_seen == 150) begin
			long_hold_done <= 1'b1;
			hold_cnt <= 80;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// Receiver: random stalls outside calm spells, and no transfers while the hold-off runs.
	always @(posedge clk or negedge arst_n) begin
		int stall;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			out_stall <= 0;
		end else begin
			stall = out_stall;
			if (out_if.valid && out_if.ready) begin
				results_seen <= results_seen + 1;
				if (expected_px.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10) begin
						$display("unexpected transfer: %h", out_if.data);
					end
				end else begin
					if (out_if.data !== expected_px[0]) begin
						errors <= errors + 1;
						if (errors < 10) begin
							$display("mismatch: expected a=%0d b=%0d c=%0d, got a=%0d b=%0d c=%0d",
								expected_px[0].out_a, expected_px[0].out_b,
								expected_px[0].out_c, out_if.data.out_a,
								out_if.data.out_b, out_if.data.out_c);
						end
					end
					void'(expected_px.pop_front());
				end
				stall = calm ? 0 : $urandom_range(0, 5);
			end
			if (hold_cnt > 0) begin
				out_if.ready <= 1'b0;
			end else if (stall > 0) begin
				out_stall <= stall - 1;
				out_if.ready <= 1'b0;
			end else begin
				out_stall <= 0;
				out_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles > 3000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int a, b, d, t, k;
		cmd_t c;
		arst_n = 1'b0;

		// Directed: black, grey, white, primaries, ties between maxima,
		// negative hue wrap, zero saturation and all six hue regions.
		add_pixel(CMD_RGB2HSV, 0, 0, 0, 0);
		add_pixel(CMD_RGB2HSV, 128, 128, 128, 0);
		add_pixel(CMD_RGB2HSV, 255, 255, 255, 255);
		add_pixel(CMD_RGB2HSV, 255, 0, 0, 0);
		add_pixel(CMD_RGB2HSV, 0, 255, 0, 0);
		add_pixel(CMD_RGB2HSV, 0, 0, 255, 0);
		add_pixel(CMD_RGB2HSV, 255, 0, 255, 0);
		add_pixel(CMD_RGB2HSV, 255, 255, 0, 0);
		add_pixel(CMD_RGB2HSV, 0, 255, 255, 0);
		add_pixel(CMD_RGB2HSV, 255, 0, 1, 0);
		add_pixel(CMD_HSV2RGB, 100, 0, 200, 0);
		for (k = 0; k < 6; k++) begin
			add_pixel(CMD_HSV2RGB, k * 43 + 21, 255, 255, 0);
		end
		add_pixel(CMD_HSV2RGB, 255, 255, 255, 0);
		add_pixel(CMD_SETSAT, 200, 50, 10, 0);
		add_pixel(CMD_SETSAT, 200, 50, 10, 255);
		add_pixel(CMD_SETSAT, 0, 0, 0, 128);
		add_pixel(CMD_CAPSAT, 200, 50, 10, 255);
		add_pixel(CMD_CAPSAT, 200, 50, 10, 0);
		add_pixel(CMD_CAPSAT, 90, 90, 90, 0);

		for (k = 0; k < 500; k++) begin
			if (k % 60 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			c = cmd_t'($urandom_range(0, 3));
			a = $urandom_range(0, 255);
			b = $urandom_range(0, 255);
			d = $urandom_range(0, 255);
			case ($urandom_range(0, 7))
				0: begin b = a; d = a; end
				1: b = a;
				2: d = b;
				3: begin a = 0; b = 0; d = 0; end
				default: ;
			endcase
			case ($urandom_range(0, 4))
				0: t = 0;
				1: t = 255;
				default: t = $urandom_range(0, 255);
			endcase
			add_pixel(c, a, b, d, t);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_px.size() == 0 && !in_if.valid && expected_px.size() == 0);
		repeat (30) @(posedge clk);
		if (errors == 0 && expected_px.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

// ===== rgb_hsv_convert_and_saturate.f =====
+incdir+hdl
hdl/rhs_pkg.sv
hdl/rhs_if.sv
hdl/rgb_hsv_convert_and_saturate.sv
dv/tb_top.sv
